>>> design/bstl_pkg.sv
// bstl_pkg: shared constants and types of the binary stl face parser
// no dependencies; imported by bstl_vtx_fix, bstl_framer and binary_stl_face_parser
package bstl_pkg;

   // file layout
   localparam logic [6:0] HDR_BYTES  = 7'd80;
   localparam logic [6:0] CNT_END    = 7'd84;
   localparam logic [5:0] NORM_BYTES = 6'd12;
   localparam logic [5:0] VTX_LAST   = 6'd47;
   localparam logic [5:0] REC_LAST   = 6'd49;

   localparam int VTX_WORDS  = 9;
   localparam int VTX_STORED = 35;   // vertex bytes held before the last one arrives

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ALL_BAD   = 2'd1;
   localparam logic [1:0] ST_TRUNC_HDR = 2'd2;
   localparam logic [1:0] ST_TRUNC_FACE = 2'd3;

   typedef logic [VTX_WORDS-1:0][31:0] vtx_words_type;

   typedef struct packed {
      vtx_words_type vert;
      logic [31:0]   face_index;
      logic [1:0]    status;
      logic          last_face;
   } face_rsp_type;

endpackage

>>> design/binary_stl_face_parser.sv
// binary_stl_face_parser: top level, input word register, framer and result register
// depends on bstl_pkg and bstl_framer
//
//   channel | ports                              | direction | word
//   req     | req_valid/req_ready, req_data_byte | in        | one file byte + end_of_file
//   rsp     | rsp_valid/rsp_ready, rsp_*         | out       | one face or error report
//
// one byte per cycle sustained while the result is not stalled; each byte waits in the input
// register and its result, if any, enters the result register as the byte leaves it
// result valid once its byte has passed the input register and then the result register
// reset clears the framing state and both valid flags; no clearing pass is needed
// a stalled result holds its register; one more byte is still taken into the input register
module binary_stl_face_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_v0_x,
   output logic [31:0] rsp_v0_y,
   output logic [31:0] rsp_v0_z,
   output logic [31:0] rsp_v1_x,
   output logic [31:0] rsp_v1_y,
   output logic [31:0] rsp_v1_z,
   output logic [31:0] rsp_v2_x,
   output logic [31:0] rsp_v2_y,
   output logic [31:0] rsp_v2_z,
   output logic [31:0] rsp_face_index,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_face
);
   import bstl_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         in_eof_ff;
   logic         out_valid_ff, out_valid_in;
   face_rsp_type out_ff;
   face_rsp_type res;
   logic         res_valid;
   logic         advance;
   logic         step;

   assign advance   = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   bstl_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (in_byte_ff),
      .end_of_file (in_eof_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = step && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_eof_ff  <= req_end_of_file;
      end
      if (step && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_v0_x       = out_ff.vert[0];
   assign rsp_v0_y       = out_ff.vert[1];
   assign rsp_v0_z       = out_ff.vert[2];
   assign rsp_v1_x       = out_ff.vert[3];
   assign rsp_v1_y       = out_ff.vert[4];
   assign rsp_v1_z       = out_ff.vert[5];
   assign rsp_v2_x       = out_ff.vert[6];
   assign rsp_v2_y       = out_ff.vert[7];
   assign rsp_v2_z       = out_ff.vert[8];
   assign rsp_face_index = out_ff.face_index;
   assign rsp_status     = out_ff.status;
   assign rsp_last_face  = out_ff.last_face;

endmodule

>>> design/bstl_vtx_fix.sv
// bstl_vtx_fix: finite check of three vertices and replacement by the first finite one
// depends on bstl_pkg
module bstl_vtx_fix (
   input  bstl_pkg::vtx_words_type words,
   output bstl_pkg::vtx_words_type fixed,
   output logic                    all_bad
);
   import bstl_pkg::*;

   logic [2:0] fin;
   logic [1:0] src;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fin[i] = (words[3*i][30:23] != 8'hFF) && (words[3*i+1][30:23] != 8'hFF) &&
                  (words[3*i+2][30:23] != 8'hFF);
      end
      all_bad = (fin == 3'b000);
      priority if (fin[0]) begin
         src = 2'd0;
      end else if (fin[1]) begin
         src = 2'd1;
      end else begin
         src = 2'd2;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            fixed[3*i+j] = fin[i] ? words[3*i+j] : words[3*src+j];
         end
      end
   end

endmodule

>>> design/bstl_framer.sv
// bstl_framer: header and face record framing, face count, vertex byte capture
// depends on bstl_pkg and bstl_vtx_fix
module bstl_framer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   end_of_file,
   output logic                   res_valid,
   output bstl_pkg::face_rsp_type res
);
   import bstl_pkg::*;

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_FACE   = 2'd1;
   localparam logic [1:0] PH_IGNORE = 2'd2;

   logic [1:0]              phase_ff, phase_in;
   logic [6:0]              hdr_pos_ff, hdr_pos_in;
   logic [31:0]             declared_ff, declared_in;
   logic [31:0]             done_ff, done_in;
   logic [5:0]              rec_pos_ff, rec_pos_in;
   logic [8*VTX_STORED-1:0] vbytes_ff, vbytes_in;

   vtx_words_type words;
   vtx_words_type fixed;
   logic          all_bad;

   // newest byte completes the vertex block on the last vertex byte
   assign words = {data_byte, vbytes_ff};

   bstl_vtx_fix u_fix (
      .words   (words),
      .fixed   (fixed),
      .all_bad (all_bad)
   );

   function automatic face_rsp_type err_rsp(input logic [31:0] idx, input logic [1:0] st);
      face_rsp_type r;
      r            = '0;
      r.face_index = idx;
      r.status     = st;
      return r;
   endfunction

   always_comb begin
      logic [6:0]  hdr_inc;
      logic [31:0] done_inc;
      logic        last;
      hdr_inc     = hdr_pos_ff + 7'd1;
      done_inc    = done_ff + 32'd1;
      last        = (done_inc == declared_ff);
      phase_in    = phase_ff;
      hdr_pos_in  = hdr_pos_ff;
      declared_in = declared_ff;
      done_in     = done_ff;
      rec_pos_in  = rec_pos_ff;
      vbytes_in   = vbytes_ff;
      res_valid   = 1'b0;
      res         = '0;

      unique case (phase_ff)
         PH_HEADER: begin
            if (hdr_pos_ff >= HDR_BYTES && hdr_pos_ff < CNT_END) begin
               declared_in = declared_ff |
                             ({24'd0, data_byte} << {hdr_pos_ff[1:0], 3'b000});
            end
            hdr_pos_in = hdr_inc;
            if (hdr_inc >= CNT_END) begin
               phase_in   = (declared_in != 32'd0) ? PH_FACE : PH_IGNORE;
               rec_pos_in = 6'd0;
               if (end_of_file && declared_in != 32'd0) begin
                  res_valid = 1'b1;
                  res       = err_rsp(32'd0, ST_TRUNC_FACE);
               end
            end else if (end_of_file) begin
               res_valid = 1'b1;
               res       = err_rsp(32'd0, ST_TRUNC_HDR);
            end
         end
         PH_FACE: begin
            if (rec_pos_ff >= NORM_BYTES && rec_pos_ff < VTX_LAST) begin
               vbytes_in = {data_byte, vbytes_ff[8*VTX_STORED-1:8]};
            end
            if (rec_pos_ff == VTX_LAST) begin
               res_valid = 1'b1;
               done_in   = done_inc;
               if (all_bad) begin
                  res      = err_rsp(done_ff, ST_ALL_BAD);
                  phase_in = PH_IGNORE;
               end else if (end_of_file && !last) begin
                  res = err_rsp(done_inc, ST_TRUNC_FACE);
               end else begin
                  res.vert       = fixed;
                  res.face_index = done_ff;
                  res.status     = ST_OK;
                  res.last_face  = last;
                  if (last) begin
                     phase_in = PH_IGNORE;
                  end
               end
            end else if (end_of_file) begin
               res_valid = 1'b1;
               res       = err_rsp(done_ff, ST_TRUNC_FACE);
            end
            rec_pos_in = (rec_pos_ff == REC_LAST) ? 6'd0 : rec_pos_ff + 6'd1;
         end
         default: begin
            // ignore phase: bytes dropped until end of file
         end
      endcase

      if (end_of_file) begin
         phase_in    = PH_HEADER;
         hdr_pos_in  = 7'd0;
         declared_in = 32'd0;
         done_in     = 32'd0;
         rec_pos_in  = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hdr_pos_ff  <= 7'd0;
         declared_ff <= 32'd0;
         done_ff     <= 32'd0;
         rec_pos_ff  <= 6'd0;
      end else if (step) begin
         phase_ff    <= phase_in;
         hdr_pos_ff  <= hdr_pos_in;
         declared_ff <= declared_in;
         done_ff     <= done_in;
         rec_pos_ff  <= rec_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         vbytes_ff <= vbytes_in;
      end
   end

endmodule
